>>> hdl/bilxb_pkg.sv
package bilxb_pkg;

  // fixed field widths
  localparam int PIX_W      = 32;
  localparam int CHAN_W     = 8;
  localparam int WGT_IN_W   = 9;
  localparam int NUM_PIX    = 4;
  localparam int NUM_CHAN   = 3;
  localparam int IN_FIELD_W = NUM_PIX * PIX_W + WGT_IN_W;
  localparam int IN_TDATA_W = ((IN_FIELD_W + 7) / 8) * 8;

  // source pixel byte positions
  localparam int SRC_RED_LSB   = 0;
  localparam int SRC_GREEN_LSB = 8;
  localparam int SRC_BLUE_LSB  = 16;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // pixel slots within in_tdata
  typedef enum logic [1:0] {
    PIX_TL = 2'd0,
    PIX_TR = 2'd1,
    PIX_BL = 2'd2,
    PIX_BR = 2'd3
  } pix_slot_t;

  // output channel slots
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_slot_t;

  // load enables of the datapath stages behind the input stage
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

>>> hdl/bilxb_chan.sv
module bilxb_chan #(
  parameter int WEIGHT_BITS = 8
) (
  input  logic                          clk,
  input  bilxb_pkg::stage_en_t          en,
  input  logic [bilxb_pkg::CHAN_W-1:0]  tl,
  input  logic [bilxb_pkg::CHAN_W-1:0]  tr,
  input  logic [bilxb_pkg::CHAN_W-1:0]  bl,
  input  logic [bilxb_pkg::CHAN_W-1:0]  br,
  input  logic [WEIGHT_BITS:0]          cw,
  input  logic [WEIGHT_BITS:0]          cw_inv,
  input  logic [WEIGHT_BITS:0]          rw,
  input  logic [WEIGHT_BITS:0]          rw_inv,
  output logic [bilxb_pkg::CHAN_W-1:0]  chan
);

  localparam int CW = bilxb_pkg::CHAN_W;
  localparam int WW = WEIGHT_BITS + 1;
  localparam int HW = CW + WEIGHT_BITS;        // row blend, at most 255*W
  localparam int SW = CW + 2 * WEIGHT_BITS;    // full sum, at most 255*W*W
  localparam logic [SW-1:0] HALF = SW'(1) << (2 * WEIGHT_BITS - 1);

  // stage 2: horizontal blend of both rows
  logic [HW-1:0] top_r, top_nxt;
  logic [HW-1:0] bot_r, bot_nxt;
  logic [WW-1:0] rw2_r, rwi2_r;
  // stage 3: vertical products
  logic [SW-1:0] vtop_r, vtop_nxt;
  logic [SW-1:0] vbot_r, vbot_nxt;
  // stage 4: rounded channel
  logic [SW-1:0] sum;
  logic [CW-1:0] chan_r;

  always_comb begin
    top_nxt  = HW'({{WW{1'b0}}, tl} * {{CW{1'b0}}, cw_inv})
             + HW'({{WW{1'b0}}, tr} * {{CW{1'b0}}, cw});
    bot_nxt  = HW'({{WW{1'b0}}, bl} * {{CW{1'b0}}, cw_inv})
             + HW'({{WW{1'b0}}, br} * {{CW{1'b0}}, cw});
    vtop_nxt = SW'({{WW{1'b0}}, top_r} * {{HW{1'b0}}, rwi2_r});
    vbot_nxt = SW'({{WW{1'b0}}, bot_r} * {{HW{1'b0}}, rw2_r});
    sum      = vtop_r + vbot_r + HALF;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      top_r  <= top_nxt;
      bot_r  <= bot_nxt;
      rw2_r  <= rw;
      rwi2_r <= rw_inv;
    end
    if (en.s3) begin
      vtop_r <= vtop_nxt;
      vbot_r <= vbot_nxt;
    end
    if (en.s4) begin
      chan_r <= sum[SW-1 -: CW];
    end
  end

  assign chan = chan_r;

endmodule

>>> hdl/bilinear_rgba_to_xrgb_blend_core.sv
// bilinear rgba8888 to xrgb8888 blend core. every input transaction carries the
// four source pixels around one output pixel (top-left, top-right, bottom-left,
// bottom-right; red in byte 0, green byte 1, blue byte 2, alpha ignored), the
// column weight of the right pixel and a last-of-row mark. the row weight of the
// bottom row comes from cfg_wr_data and must be set per output row while the
// core is idle; the core itself does not enforce this. weights are fixed point
// with WEIGHT_BITS fraction bits, 2^WEIGHT_BITS is 1.0 and larger values
// saturate to 1.0. each of red, green and blue is blended horizontally, then
// vertically, rounded half up and truncated; the result is blue in byte 0,
// green byte 1, red byte 2 and 0xff on top. the core is a four-stage pipeline
// (unpack and clamp, horizontal multiply-add, vertical multiply, round and
// pack), so it takes one pixel per clock while the output is not stalled.
// every stage has its own valid bit and loads whenever it is empty or its
// successor loads, so backpressure on the output only stalls the stages that
// are full and no transaction is dropped or repeated.
module bilinear_rgba_to_xrgb_blend_core #(
  parameter int WEIGHT_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // config
  input  logic                              cfg_wr_en,
  input  logic [bilxb_pkg::WGT_IN_W-1:0]    cfg_wr_data,    // bottom row weight
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // top_left_pixel, top_right_pixel, bottom_left_pixel, bottom_right_pixel,
  // col weight, zero pad
  input  logic [bilxb_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                              in_tlast,       // last_in_row
  // output stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bilxb_pkg::PIX_W-1:0]       out_tdata,      // output_pixel
  output logic                              out_tlast       // last_out
);

  localparam int WW    = WEIGHT_BITS + 1;
  localparam int CLW   = (WW > bilxb_pkg::WGT_IN_W) ? WW : bilxb_pkg::WGT_IN_W;
  localparam logic [CLW-1:0] ONE_CL = CLW'(1) << WEIGHT_BITS;
  localparam logic [WW-1:0]  ONE_W  = WW'(1) << WEIGHT_BITS;
  localparam int PW    = bilxb_pkg::PIX_W;
  localparam int CHW   = bilxb_pkg::CHAN_W;
  localparam int CWOFF = bilxb_pkg::NUM_PIX * bilxb_pkg::PIX_W;

  // row weight register
  logic [bilxb_pkg::WGT_IN_W-1:0] row_wgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_wgt_r <= '0;
    end else if (cfg_wr_en) begin
      row_wgt_r <= cfg_wr_data;
    end
  end

  // saturate a weight to 1.0
  function automatic logic [WW-1:0] clamp_w(input logic [bilxb_pkg::WGT_IN_W-1:0] w);
    logic [CLW-1:0] ext;
    ext = CLW'(w);
    clamp_w = (ext > ONE_CL) ? ONE_W : WW'(ext);
  endfunction

  // pipeline control: a stage loads when it is empty or its successor loads
  logic [4:1] vld_r;
  logic [5:1] rdy;
  bilxb_pkg::stage_en_t en;

  always_comb begin
    rdy[5] = out_tready;
    for (int k = 4; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    en.s2 = rdy[2];
    en.s3 = rdy[3];
    en.s4 = rdy[4];
  end

  assign in_tready = rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) vld_r[1] <= in_tvalid;
      for (int k = 2; k <= 4; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // stage 1: unpack channels, clamp weights
  logic [CHW-1:0] px_r [bilxb_pkg::NUM_CHAN][bilxb_pkg::NUM_PIX];
  logic [WW-1:0]  cw_r, cwi_r, rw_r, rwi_r;
  logic [WW-1:0]  cw_nxt, rw_nxt;
  logic [4:1]     last_r;

  assign cw_nxt = clamp_w(in_tdata[CWOFF +: bilxb_pkg::WGT_IN_W]);
  assign rw_nxt = clamp_w(row_wgt_r);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int p = 0; p < bilxb_pkg::NUM_PIX; p++) begin
        px_r[bilxb_pkg::CH_RED][p]   <= in_tdata[p*PW + bilxb_pkg::SRC_RED_LSB   +: CHW];
        px_r[bilxb_pkg::CH_GREEN][p] <= in_tdata[p*PW + bilxb_pkg::SRC_GREEN_LSB +: CHW];
        px_r[bilxb_pkg::CH_BLUE][p]  <= in_tdata[p*PW + bilxb_pkg::SRC_BLUE_LSB  +: CHW];
      end
      cw_r      <= cw_nxt;
      cwi_r     <= ONE_W - cw_nxt;
      rw_r      <= rw_nxt;
      rwi_r     <= ONE_W - rw_nxt;
      last_r[1] <= in_tlast;
    end
    for (int k = 2; k <= 4; k++) begin
      if (rdy[k]) last_r[k] <= last_r[k-1];
    end
  end

  // stages 2 to 4: one blend datapath per color channel
  logic [CHW-1:0] chan [bilxb_pkg::NUM_CHAN];

  for (genvar c = 0; c < bilxb_pkg::NUM_CHAN; c++) begin : g_chan
    bilxb_chan #(
      .WEIGHT_BITS (WEIGHT_BITS)
    ) u_chan (
      .clk    (clk),
      .en     (en),
      .tl     (px_r[c][bilxb_pkg::PIX_TL]),
      .tr     (px_r[c][bilxb_pkg::PIX_TR]),
      .bl     (px_r[c][bilxb_pkg::PIX_BL]),
      .br     (px_r[c][bilxb_pkg::PIX_BR]),
      .cw     (cw_r),
      .cw_inv (cwi_r),
      .rw     (rw_r),
      .rw_inv (rwi_r),
      .chan   (chan[c])
    );
  end

  // xrgb packing: blue low, then green, red, opaque top byte
  assign out_tvalid = vld_r[4];
  assign out_tdata  = {bilxb_pkg::ALPHA_OPAQUE, chan[bilxb_pkg::CH_RED],
                       chan[bilxb_pkg::CH_GREEN], chan[bilxb_pkg::CH_BLUE]};
  assign out_tlast  = last_r[4];

endmodule

>>> hdl/bilxb_check.sv
module bilxb_check (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [bilxb_pkg::PIX_W-1:0] out_tdata,
  input logic                        out_tlast
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped under backpressure");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output payload changed under backpressure");

  // top byte is always opaque
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:24] == bilxb_pkg::ALPHA_OPAQUE)
    else $error("output alpha byte not opaque");

  // an open output lets the whole pipeline move
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output ready");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind bilinear_rgba_to_xrgb_blend_core bilxb_check u_bilxb_check (.*);
